@@ sv/lfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Line format sniffer package
// Shared types, widths and constants of the scan-line format detector.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int FIELD_W    = 12;
    localparam int ONE_BIT_W  = 25;
    localparam int FOUR_BIT_W = 27;
    localparam int REC_CNT_W  = 13;
    localparam int STREAK_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Saturation point of the same-format streak.
    localparam logic [STREAK_W-1:0] STREAK_TARGET = 2'd3;

    localparam logic [REC_CNT_W-1:0] MAX_RECORDS_RST = 13'd5000;

    // One-bit length: a zero blank count stands for a full line.
    localparam logic [ONE_BIT_W-1:0] FULL_LINE     = 25'd4096;
    localparam logic [ONE_BIT_W-1:0] HALF_LINE     = 25'd2048;
    localparam logic [ONE_BIT_W-1:0] SNAP_LO       = 25'd4084;
    localparam logic [ONE_BIT_W-1:0] RAW_ONE_STEP  = 25'd12;
    localparam logic [FOUR_BIT_W-1:0] RAW_FOUR_STEP = 27'd4;
    localparam logic [FOUR_BIT_W-1:0] FOUR_FULL_LINE = 27'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_CAMERA = 1'b0,
        CFG_MAX_RECORDS   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_UNKNOWN   = 2'd0,
        FMT_THREE_BIT = 2'd1,
        FMT_BINARY    = 2'd2
    } t_fmt;

    typedef struct packed {
        logic               camera;
        logic               end_of_line;
        logic               raw;
        logic [FIELD_W-1:0] run_or_pixels;
    } t_rec;

    // Event from the line accumulator toward the streak tracker.
    typedef struct packed {
        logic emit;
        logic limit_hit;
        t_fmt fmt;
    } t_line_evt;

endpackage

@@ sv/lfs_rec_if.sv @@
// ----------------------------------------------------------------------------
// Scan record channel
// Valid/ready channel that carries one decoded scan record per transaction.
// ----------------------------------------------------------------------------
interface lfs_rec_if;
    logic        valid;
    logic        ready;
    logic        camera;
    logic        end_of_line;
    logic        raw;
    logic [11:0] run_or_pixels;

    modport source (output valid, output camera, output end_of_line, output raw,
                    output run_or_pixels, input ready);
    modport sink   (input valid, input camera, input end_of_line, input raw,
                    input run_or_pixels, output ready);
endinterface

@@ sv/lfs_res_if.sv @@
// ----------------------------------------------------------------------------
// Line result channel
// Valid/ready channel that carries one line format verdict per transaction.
// ----------------------------------------------------------------------------
interface lfs_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_format;
    logic       limit_hit;
    logic [1:0] agree_streak;
    logic       settled;

    modport source (output valid, output line_format, output limit_hit,
                    output agree_streak, output settled, input ready);
    modport sink   (input valid, input line_format, input limit_hit,
                    input agree_streak, input settled, output ready);
endinterface

@@ sv/lfs_line_acc.sv @@
// ----------------------------------------------------------------------------
// Line accumulator
// Counts records per line, keeps the one-bit and four-bit running lengths and
// judges the line format at end of line or when the record limit is passed.
// ----------------------------------------------------------------------------
module lfs_line_acc import lfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  t_rec                 i_rec,
    input  logic                 i_target_camera,
    input  logic [REC_CNT_W-1:0] i_max_records,
    output t_line_evt            o_evt
);

    logic [ONE_BIT_W-1:0]  r_one_len,  n_one_len;
    logic [FOUR_BIT_W-1:0] r_four_len, n_four_len;
    logic [REC_CNT_W-1:0]  r_rec_cnt,  n_rec_cnt;

    logic [REC_CNT_W:0]    rec_inc;
    logic                  over_limit;
    logic [ONE_BIT_W-1:0]  one_upd;
    logic [FOUR_BIT_W-1:0] four_upd;
    logic [ONE_BIT_W-1:0]  blank_cnt;
    t_fmt                  fmt;

    always_comb begin
        rec_inc    = {1'b0, r_rec_cnt} + (REC_CNT_W+1)'(1);
        over_limit = rec_inc > {1'b0, i_max_records};

        blank_cnt = (i_rec.run_or_pixels == '0) ? FULL_LINE
                                                : ONE_BIT_W'(i_rec.run_or_pixels);
        if (!i_rec.raw) begin
            one_upd  = r_one_len + blank_cnt;
            four_upd = r_four_len + FOUR_BIT_W'({i_rec.run_or_pixels, 2'b00});
        end else begin
            four_upd = r_four_len + RAW_FOUR_STEP;
            // A raw record close to a full line is taken as completing it.
            if (r_one_len >= SNAP_LO && r_one_len < FULL_LINE) begin
                one_upd = FULL_LINE;
            end else begin
                one_upd = r_one_len + RAW_ONE_STEP;
            end
        end

        if (four_upd == FOUR_FULL_LINE) begin
            fmt = FMT_THREE_BIT;
        end else if (one_upd == HALF_LINE || one_upd == FULL_LINE) begin
            fmt = FMT_BINARY;
        end else begin
            fmt = FMT_UNKNOWN;
        end

        o_evt      = '{emit: 1'b0, limit_hit: 1'b0, fmt: FMT_UNKNOWN};
        n_one_len  = r_one_len;
        n_four_len = r_four_len;
        n_rec_cnt  = rec_inc[REC_CNT_W-1:0];

        priority if (over_limit) begin
            o_evt      = '{emit: 1'b1, limit_hit: 1'b1, fmt: FMT_UNKNOWN};
            n_one_len  = '0;
            n_four_len = '0;
            n_rec_cnt  = '0;
        end else if (i_rec.camera != i_target_camera) begin
            // Records of the other camera only count toward the limit.
        end else if (i_rec.end_of_line) begin
            o_evt      = '{emit: 1'b1, limit_hit: 1'b0, fmt: fmt};
            n_one_len  = '0;
            n_four_len = '0;
            n_rec_cnt  = '0;
        end else begin
            n_one_len  = one_upd;
            n_four_len = four_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_len  <= '0;
            r_four_len <= '0;
            r_rec_cnt  <= '0;
        end else if (i_step) begin
            r_one_len  <= n_one_len;
            r_four_len <= n_four_len;
            r_rec_cnt  <= n_rec_cnt;
        end
    end

endmodule

@@ sv/lfs_streak.sv @@
// ----------------------------------------------------------------------------
// Format streak tracker
// Counts consecutive lines that report the same known format, saturating.
// ----------------------------------------------------------------------------
module lfs_streak import lfs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_line_evt           i_evt,
    output logic [STREAK_W-1:0] o_streak,
    output logic                o_settled
);

    t_fmt                r_prev_fmt;
    logic [STREAK_W-1:0] r_streak, n_streak;

    always_comb begin
        if (i_evt.fmt == FMT_UNKNOWN || i_evt.fmt != r_prev_fmt) begin
            n_streak = '0;
        end else if (r_streak < STREAK_TARGET) begin
            n_streak = r_streak + STREAK_W'(1);
        end else begin
            n_streak = r_streak;
        end
        o_streak  = n_streak;
        o_settled = n_streak >= STREAK_TARGET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fmt <= FMT_UNKNOWN;
            r_streak   <= '0;
        end else if (i_step && i_evt.emit) begin
            r_prev_fmt <= i_evt.fmt;
            r_streak   <= n_streak;
        end
    end

endmodule

@@ sv/line_format_sniffer.sv @@
// ----------------------------------------------------------------------------
// Line format sniffer
// Watches decoded scan records and reports the pixel format of each line.
// ----------------------------------------------------------------------------
// Usage:
// Records enter on i_rec, one per transaction. Every record counts toward the
// per-line record limit; only records of the selected camera add to the line
// lengths. A selected-camera record with end_of_line set, or any record that
// pushes the line past max_records, yields one transaction on o_res.
// A record is captured in an input register and processed together with the
// running line state once the output register is free or draining. Any verdict
// is then loaded into the output register, which drives o_res.valid.
// The sustained rate is one record per cycle while o_res is not stalled; the
// line state update is combinational logic on the registered record.
// When o_res is stalled the output register holds its verdict, and the input
// register does not advance until that verdict drains, whether or not its
// record gives a verdict. i_rec.ready drops once a record waits there.
// Reset clears the line lengths, record count and streak, sets the target
// camera to 0 and the record limit to 5000. The user must write configuration
// only while no record is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module line_format_sniffer import lfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lfs_rec_if.sink               i_rec,
    lfs_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_target_camera;
    logic [REC_CNT_W-1:0] r_max_records;

    logic                 r_in_valid;
    t_rec                 r_in;
    logic                 r_out_valid;
    t_fmt                 r_out_fmt;
    logic                 r_out_limit;
    logic [STREAK_W-1:0]  r_out_streak;
    logic                 r_out_settled;

    logic                 proc;
    logic                 in_accept;
    t_line_evt            evt;
    logic [STREAK_W-1:0]  streak;
    logic                 settled;

    // A record may advance whenever the output register is free or draining.
    assign proc        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rec.ready = !r_in_valid || proc;
    assign in_accept   = i_rec.valid && i_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_camera <= 1'b0;
            r_max_records   <= MAX_RECORDS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_CAMERA: r_target_camera <= i_cfg_data[0];
                CFG_MAX_RECORDS:   r_max_records   <= i_cfg_data[REC_CNT_W-1:0];
                default:           r_target_camera <= r_target_camera;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= '{camera: i_rec.camera, end_of_line: i_rec.end_of_line,
                      raw: i_rec.raw, run_or_pixels: i_rec.run_or_pixels};
        end
    end

    lfs_line_acc u_line_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (proc),
        .i_rec           (r_in),
        .i_target_camera (r_target_camera),
        .i_max_records   (r_max_records),
        .o_evt           (evt)
    );

    lfs_streak u_streak (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (proc),
        .i_evt     (evt),
        .o_streak  (streak),
        .o_settled (settled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && evt.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && evt.emit) begin
            r_out_fmt     <= evt.fmt;
            r_out_limit   <= evt.limit_hit;
            r_out_streak  <= streak;
            r_out_settled <= settled;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.line_format  = r_out_fmt;
    assign o_res.limit_hit    = r_out_limit;
    assign o_res.agree_streak = r_out_streak;
    assign o_res.settled      = r_out_settled;

endmodule

@@ sv/lfs_checker.sv @@
// ----------------------------------------------------------------------------
// Line format sniffer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lfs_checker import lfs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic [1:0]          i_line_format,
    input logic                i_limit_hit,
    input logic [STREAK_W-1:0] i_agree_streak,
    input logic                i_settled
);

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
            $stable({i_line_format, i_limit_hit, i_agree_streak, i_settled}))
        else $error("result changed while stalled");

    // A line cut off by the record limit is always unknown and breaks the streak.
    a_limit_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_limit_hit |->
            i_line_format == FMT_UNKNOWN && i_agree_streak == '0)
        else $error("limit result with a format or streak");

    a_unknown_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_line_format == FMT_UNKNOWN |-> i_agree_streak == '0)
        else $error("unknown format with nonzero streak");

    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_settled == (i_agree_streak >= STREAK_TARGET))
        else $error("settled flag disagrees with streak");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind line_format_sniffer lfs_checker u_lfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_line_format  (o_res.line_format),
    .i_limit_hit    (o_res.limit_hit),
    .i_agree_streak (o_res.agree_streak),
    .i_settled      (o_res.settled)
);
